// ===== rtl/twc_pkg.sv =====
// ----------------------------------------------------------------------------
// twc_pkg
// shared types and constants of the timed watering controller
// ----------------------------------------------------------------------------
package twc_pkg;

    localparam int FLOW_WIDTH = 32;

    // key bit positions
    localparam int KEY_ENABLE = 0;
    localparam int KEY_UP     = 1;
    localparam int KEY_DOWN   = 2;
    localparam int KEY_SELECT = 5;

    localparam logic [4:0]  HOUR_LAST = 5'd23;
    localparam logic [5:0]  MIN_LAST  = 6'd59;
    localparam logic [13:0] VOL_MAX   = 14'd9950;
    localparam logic [13:0] VOL_MIN   = 14'd50;
    localparam logic [13:0] VOL_STEP  = 14'd50;
    localparam logic [10:0] MIN_PER_HOUR = 11'd60;
    localparam logic signed [11:0] MIN_PER_DAY = 12'sd1440;
    localparam logic signed [7:0]  SEC_PER_MIN = 8'sd60;

    // reset values of the settings
    localparam logic [4:0]  RST_SCHED_HOUR   = 5'd6;
    localparam logic [5:0]  RST_START_MINUTE = 6'd0;
    localparam logic [5:0]  RST_START_SECOND = 6'd1;
    localparam logic [13:0] RST_VOL_TARGET   = 14'd100;

    typedef enum logic [1:0] {
        SEL_HOUR,
        SEL_MINUTE,
        SEL_SECOND,
        SEL_VOLUME
    } sel_t;

    typedef struct packed {
        logic [5:0]            prev_keys;
        logic                  enabled;
        logic                  watering;
        logic                  done_today;
        sel_t                  edit_sel;
        logic [4:0]            sched_hour;
        logic [5:0]            start_minute;
        logic [5:0]            start_second;
        logic [13:0]           vol_target;
        logic [13:0]           vol_left;
        logic [FLOW_WIDTH-1:0] flow_at_start;
        logic [10:0]           run_start_min;
        logic [5:0]            run_start_sec;
        logic                  params_shown;
    } twc_state_t;

    typedef struct packed {
        logic        finished;
        logic        save;
        logic        refresh;
        logic [10:0] minutes;
        logic [5:0]  seconds;
    } twc_sched_flags_t;

endpackage

// ===== rtl/timed_watering_controller.sv =====
// ----------------------------------------------------------------------------
// timed_watering_controller
// daily volume-dosing valve controller with key editing and run records
// ----------------------------------------------------------------------------
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_ready  | keys, second_tick, clock_*, flow_total
//  out     | out_valid / out_ready| valve_open .. save_flow (one result per request)
//
//  one request per cycle sustained while out_ready is high; a taken request
//  goes to the input register, then its result to the result register
//  settings edits and the schedule update are one combinational pass
//  reset clears the state at once to its defaults; no clearing pass
//  with out_ready low the result register holds, the input register takes
//  one more request and then in_ready drops
// ----------------------------------------------------------------------------
module timed_watering_controller (
    input  logic                           clk,
    input  logic                           rst_n,
    // request channel
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [5:0]                     keys,
    input  logic                           second_tick,
    input  logic [4:0]                     clock_hour,
    input  logic [5:0]                     clock_minute,
    input  logic [5:0]                     clock_second,
    input  logic [twc_pkg::FLOW_WIDTH-1:0] flow_total,
    // result channel
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           valve_open,
    output logic                           schedule_enabled,
    output logic                           show_params,
    output logic                           refresh_display,
    output logic [1:0]                     param_select,
    output logic [13:0]                    remaining_volume,
    output logic [13:0]                    target_volume,
    output logic                           run_finished,
    output logic [twc_pkg::FLOW_WIDTH-1:0] delivered_volume,
    output logic [10:0]                    run_minutes,
    output logic [5:0]                     run_seconds,
    output logic                           save_flow
);
    import twc_pkg::*;

    // input register
    logic                  in_valid_reg;
    logic [5:0]            keys_reg;
    logic                  tick_reg;
    logic [4:0]            hour_reg;
    logic [5:0]            minute_reg;
    logic [5:0]            second_reg;
    logic [FLOW_WIDTH-1:0] flow_reg;

    // controller state
    twc_state_t state_reg;
    twc_state_t state_key;
    twc_state_t state_next;

    // result register
    logic                  out_valid_reg;
    logic                  valve_reg;
    logic                  enabled_reg;
    logic                  shown_reg;
    logic                  refresh_reg;
    logic [1:0]            select_reg;
    logic [13:0]           left_reg;
    logic [13:0]           target_reg;
    logic                  finished_reg;
    logic [FLOW_WIDTH-1:0] delivered_reg;
    logic [10:0]           minutes_reg;
    logic [5:0]            seconds_reg;
    logic                  save_reg;

    logic                  key_refresh;
    logic                  stop_run;
    twc_sched_flags_t      sched_flags;
    logic [FLOW_WIDTH-1:0] delivered;
    logic                  advance;
    logic                  in_take;

    // the request in the input register moves on when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    // key handling first, then the one-second schedule update
    twc_key_edit u_key_edit (
        .keys      (keys_reg),
        .cur_state (state_reg),
        .new_state (state_key),
        .refresh   (key_refresh),
        .stop_run  (stop_run)
    );

    twc_schedule u_schedule (
        .second_tick  (tick_reg),
        .stop_run     (stop_run),
        .clock_hour   (hour_reg),
        .clock_minute (minute_reg),
        .clock_second (second_reg),
        .flow_total   (flow_reg),
        .cur_state    (state_key),
        .new_state    (state_next),
        .flags        (sched_flags),
        .delivered    (delivered)
    );

    // handshake flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
                in_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // state moves only when a request is processed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.prev_keys     <= 6'd0;
            state_reg.enabled       <= 1'b0;
            state_reg.watering      <= 1'b0;
            state_reg.done_today    <= 1'b0;
            state_reg.edit_sel      <= SEL_HOUR;
            state_reg.sched_hour    <= RST_SCHED_HOUR;
            state_reg.start_minute  <= RST_START_MINUTE;
            state_reg.start_second  <= RST_START_SECOND;
            state_reg.vol_target    <= RST_VOL_TARGET;
            state_reg.vol_left      <= 14'd0;
            state_reg.flow_at_start <= '0;
            state_reg.run_start_min <= 11'd0;
            state_reg.run_start_sec <= 6'd0;
            state_reg.params_shown  <= 1'b0;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // input payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            keys_reg   <= keys;
            tick_reg   <= second_tick;
            hour_reg   <= clock_hour;
            minute_reg <= clock_minute;
            second_reg <= clock_second;
            flow_reg   <= flow_total;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            valve_reg     <= state_next.watering;
            enabled_reg   <= state_next.enabled;
            shown_reg     <= state_next.params_shown;
            refresh_reg   <= key_refresh | sched_flags.refresh;
            select_reg    <= state_next.edit_sel;
            left_reg      <= state_next.vol_left;
            target_reg    <= state_next.vol_target;
            finished_reg  <= sched_flags.finished;
            delivered_reg <= delivered;
            minutes_reg   <= sched_flags.minutes;
            seconds_reg   <= sched_flags.seconds;
            save_reg      <= sched_flags.save;
        end
    end

    assign out_valid        = out_valid_reg;
    assign valve_open       = valve_reg;
    assign schedule_enabled = enabled_reg;
    assign show_params      = shown_reg;
    assign refresh_display  = refresh_reg;
    assign param_select     = select_reg;
    assign remaining_volume = left_reg;
    assign target_volume    = target_reg;
    assign run_finished     = finished_reg;
    assign delivered_volume = delivered_reg;
    assign run_minutes      = minutes_reg;
    assign run_seconds      = seconds_reg;
    assign save_flow        = save_reg;

    // a target-reached stop always comes with a run record
    a_save_has_record: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && save_flow |-> run_finished)
        else $error("save_flow without run_finished");

    // a finished run leaves the valve closed
    a_finish_closes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && run_finished |-> !valve_open)
        else $error("valve still open after run end");

    // watering only while the schedule is armed
    a_open_armed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && valve_open |-> schedule_enabled)
        else $error("valve open while disarmed");

    // target volume stays within its limits
    a_target_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (target_volume >= VOL_MIN) && (target_volume <= VOL_MAX))
        else $error("target volume out of range");

endmodule

// ===== rtl/twc_key_edit.sv =====
// ----------------------------------------------------------------------------
// twc_key_edit
// key edge detection and settings edit: enable, mode, up, down in that order
// ----------------------------------------------------------------------------
module twc_key_edit (
    input  logic [5:0]          keys,
    input  twc_pkg::twc_state_t cur_state,
    output twc_pkg::twc_state_t new_state,
    output logic                refresh,
    output logic                stop_run
);
    import twc_pkg::*;

    logic [5:0] key_edge;
    twc_state_t s;

    assign key_edge = keys & ~cur_state.prev_keys;

    always_comb
    begin
        s        = cur_state;
        refresh  = 1'b0;
        stop_run = 1'b0;

        if (key_edge[KEY_ENABLE])
        begin
            if (s.enabled)
            begin
                s.enabled    = 1'b0;
                s.done_today = 1'b0;
                // disarm in the middle of a run closes it
                if (s.watering)
                begin
                    s.watering = 1'b0;
                    stop_run   = 1'b1;
                end
            end
            else
            begin
                s.enabled    = 1'b1;
                s.watering   = 1'b0;
                s.done_today = 1'b0;
            end
            s.params_shown = 1'b0;
            refresh        = 1'b1;
        end

        if (key_edge[KEY_SELECT])
        begin
            s.edit_sel     = sel_t'(2'(s.edit_sel + 2'd1));
            s.params_shown = 1'b1;
            refresh        = 1'b1;
        end

        if (key_edge[KEY_UP])
        begin
            unique case (s.edit_sel)
                SEL_HOUR:
                    s.sched_hour = (s.sched_hour == HOUR_LAST) ? 5'd0 : s.sched_hour + 5'd1;
                SEL_MINUTE:
                    s.start_minute = (s.start_minute == MIN_LAST) ? 6'd0
                                                                  : s.start_minute + 6'd1;
                SEL_SECOND:
                    s.start_second = (s.start_second == MIN_LAST) ? 6'd0
                                                                  : s.start_second + 6'd1;
                SEL_VOLUME:
                    if (s.vol_target < VOL_MAX)
                        s.vol_target = s.vol_target + VOL_STEP;
            endcase
            s.params_shown = 1'b1;
            refresh        = 1'b1;
        end

        if (key_edge[KEY_DOWN])
        begin
            unique case (s.edit_sel)
                SEL_HOUR:
                    s.sched_hour = (s.sched_hour == 5'd0) ? HOUR_LAST : s.sched_hour - 5'd1;
                SEL_MINUTE:
                    s.start_minute = (s.start_minute == 6'd0) ? MIN_LAST
                                                              : s.start_minute - 6'd1;
                SEL_SECOND:
                    s.start_second = (s.start_second == 6'd0) ? MIN_LAST
                                                              : s.start_second - 6'd1;
                SEL_VOLUME:
                    if (s.vol_target > VOL_MIN)
                        s.vol_target = s.vol_target - VOL_STEP;
            endcase
            s.params_shown = 1'b1;
            refresh        = 1'b1;
        end

        s.prev_keys = keys;
    end

    assign new_state = s;

endmodule

// ===== rtl/twc_schedule.sv =====
// ----------------------------------------------------------------------------
// twc_schedule
// per-second schedule update, run start and stop, run record
// ----------------------------------------------------------------------------
module twc_schedule (
    input  logic                               second_tick,
    input  logic                               stop_run,
    input  logic [4:0]                         clock_hour,
    input  logic [5:0]                         clock_minute,
    input  logic [5:0]                         clock_second,
    input  logic [twc_pkg::FLOW_WIDTH-1:0]     flow_total,
    input  twc_pkg::twc_state_t                cur_state,
    output twc_pkg::twc_state_t                new_state,
    output twc_pkg::twc_sched_flags_t          flags,
    output logic [twc_pkg::FLOW_WIDTH-1:0]     delivered
);
    import twc_pkg::*;

    logic [FLOW_WIDTH-1:0] got;
    logic [10:0]           now_min;
    logic signed [11:0]    dm_raw;
    logic signed [11:0]    dm_norm;
    logic signed [11:0]    dm_day;
    logic signed [7:0]     ds_raw;
    logic signed [7:0]     ds_norm;
    logic                  start_match;
    logic                  midnight;
    logic                  reached;
    logic                  finish;
    twc_state_t            s;

    assign got     = flow_total - cur_state.flow_at_start;
    assign reached = got >= FLOW_WIDTH'(cur_state.vol_target);
    assign now_min = 11'(clock_hour) * MIN_PER_HOUR + 11'(clock_minute);

    // duration as minutes and seconds differences, seconds brought into 0..59
    assign dm_raw = $signed({1'b0, now_min}) - $signed({1'b0, cur_state.run_start_min});
    assign ds_raw = $signed({2'b00, clock_second}) - $signed({2'b00, cur_state.run_start_sec});

    always_comb
    begin
        if (ds_raw >= SEC_PER_MIN)
        begin
            ds_norm = ds_raw - SEC_PER_MIN;
            dm_norm = dm_raw + 12'sd1;
        end
        else if (ds_raw >= 8'sd0)
        begin
            ds_norm = ds_raw;
            dm_norm = dm_raw;
        end
        else if (ds_raw >= -SEC_PER_MIN)
        begin
            ds_norm = ds_raw + SEC_PER_MIN;
            dm_norm = dm_raw - 12'sd1;
        end
        else
        begin
            ds_norm = ds_raw + SEC_PER_MIN + SEC_PER_MIN;
            dm_norm = dm_raw - 12'sd2;
        end
    end

    // end before start means the run crossed midnight
    assign dm_day = (dm_norm < 12'sd0) ? dm_norm + MIN_PER_DAY : dm_norm;

    assign start_match = (clock_hour == cur_state.sched_hour) &&
                         (clock_minute == cur_state.start_minute) &&
                         (clock_second == cur_state.start_second);
    assign midnight    = (clock_hour == 5'd0) && (clock_minute == 6'd0) &&
                         (clock_second == 6'd0);

    always_comb
    begin
        s             = cur_state;
        finish        = stop_run;
        flags.save    = 1'b0;
        flags.refresh = 1'b0;

        if (second_tick && cur_state.enabled)
        begin
            if (cur_state.watering)
            begin
                if (reached)
                begin
                    s.watering     = 1'b0;
                    s.done_today   = 1'b1;
                    s.params_shown = 1'b0;
                    flags.save     = 1'b1;
                    flags.refresh  = 1'b1;
                    finish         = 1'b1;
                end
                else
                begin
                    s.vol_left = cur_state.vol_target - got[13:0];
                    if (!cur_state.params_shown)
                    begin
                        s.params_shown = 1'b1;
                        flags.refresh  = 1'b1;
                    end
                end
            end
            else
            begin
                if (!cur_state.done_today && start_match)
                begin
                    s.watering      = 1'b1;
                    s.vol_left      = cur_state.vol_target;
                    s.flow_at_start = flow_total;
                    s.run_start_min = now_min;
                    s.run_start_sec = clock_second;
                    s.params_shown  = 1'b1;
                    flags.refresh   = 1'b1;
                end
                if (cur_state.done_today && midnight)
                    s.done_today = 1'b0;
            end
        end

        flags.finished = finish;
        flags.minutes  = finish ? dm_day[10:0] : 11'd0;
        flags.seconds  = finish ? ds_norm[5:0] : 6'd0;
    end

    assign new_state = s;
    assign delivered = finish ? got : '0;

endmodule
